// ===== rtl/core/sfdw_pkg.sv =====
// Shared types, band tables and divider step for the frequency-to-divider-word block.
package sfdw_pkg;

  localparam int FREQ_W    = 32;               // carrier frequency width
  localparam int XTAL_W    = 27;               // crystal frequency width
  localparam int DIVSEL_W  = 5;                // output divider width
  localparam int BAND_W    = 3;                // band code width
  localparam int FC_W      = 32;               // kept quotient width
  localparam int PROD_W    = FREQ_W + DIVSEL_W;
  localparam int FC_SHIFT  = 18;               // fc carries a factor of 2^18
  localparam int FRAC_W    = 19;               // fraction bits taken from fc
  localparam int INT_W     = 8;
  localparam int STEP_BITS = 2;                // quotient bits per divider stage
  localparam int DVD_RAW_W = PROD_W + FC_SHIFT;
  localparam int N_DIV     = (DVD_RAW_W + STEP_BITS - 1) / STEP_BITS;
  localparam int DVD_W     = N_DIV * STEP_BITS;

  localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(30000000);

  // Register indexes on the configuration port.
  localparam logic REG_VARIANT = 1'b0;
  localparam logic REG_XTAL    = 1'b1;

  localparam int NUM_WIDE   = 6;
  localparam int NUM_NARROW = 4;

  localparam logic [FREQ_W-1:0] WIDE_LO [NUM_WIDE] = '{
    32'd119000000, 32'd177000000, 32'd235000000,
    32'd353000000, 32'd470000000, 32'd705000000};
  localparam logic [FREQ_W-1:0] WIDE_HI [NUM_WIDE] = '{
    32'd159000000, 32'd239000000, 32'd319000000,
    32'd479000000, 32'd639000000, 32'd960000000};
  localparam logic [DIVSEL_W-1:0] WIDE_DIV [NUM_WIDE] = '{
    5'd24, 5'd16, 5'd12, 5'd8, 5'd6, 5'd4};
  localparam logic [BAND_W-1:0] WIDE_BAND [NUM_WIDE] = '{
    3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

  localparam logic [FREQ_W-1:0] NARROW_LO [NUM_NARROW] = '{
    32'd142000000, 32'd284000000, 32'd420000000, 32'd850000000};
  localparam logic [FREQ_W-1:0] NARROW_HI [NUM_NARROW] = '{
    32'd175000000, 32'd350000000, 32'd525000000, 32'd1050000000};
  localparam logic [DIVSEL_W-1:0] NARROW_DIV [NUM_NARROW] = '{
    5'd24, 5'd12, 5'd8, 5'd4};
  localparam logic [BAND_W-1:0] NARROW_BAND [NUM_NARROW] = '{
    3'd5, 3'd3, 3'd2, 3'd0};

  typedef struct packed {
    logic                hit;
    logic [BAND_W-1:0]   band;
    logic [DIVSEL_W-1:0] div;
  } band_sel_t;

  typedef struct packed {
    logic                valid;
    logic                err;
    logic [BAND_W-1:0]   band;
    logic [DIVSEL_W-1:0] div;
    logic [XTAL_W-1:0]   rem;
    logic [DVD_W-1:0]    dvd;
    logic [FC_W-1:0]     quot;
  } div_pipe_t;

  // Open ranges on both ends; the first matching entry wins.
  function automatic band_sel_t find_band(logic [FREQ_W-1:0] f, logic wide);
    band_sel_t r;
    r = '0;
    if (wide) begin
      for (int i = 0; i < NUM_WIDE; i++) begin
        if (!r.hit && f > WIDE_LO[i] && f < WIDE_HI[i]) begin
          r.hit  = 1'b1;
          r.band = WIDE_BAND[i];
          r.div  = WIDE_DIV[i];
        end
      end
    end else begin
      for (int i = 0; i < NUM_NARROW; i++) begin
        if (!r.hit && f > NARROW_LO[i] && f < NARROW_HI[i]) begin
          r.hit  = 1'b1;
          r.band = NARROW_BAND[i];
          r.div  = NARROW_DIV[i];
        end
      end
    end
    return r;
  endfunction

  // Restoring division, STEP_BITS quotient bits. Only the low FC_W quotient
  // bits are kept; higher ones fall off the top of the shift register.
  function automatic div_pipe_t div_step(div_pipe_t s, logic [XTAL_W-1:0] d);
    div_pipe_t         r;
    logic [XTAL_W:0]   t;
    r = s;
    for (int i = 0; i < STEP_BITS; i++) begin
      t     = {r.rem, r.dvd[DVD_W-1]};
      r.dvd = {r.dvd[DVD_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem  = XTAL_W'(t - {1'b0, d});
        r.quot = {r.quot[FC_W-2:0], 1'b1};
      end else begin
        r.rem  = t[XTAL_W-1:0];
        r.quot = {r.quot[FC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/synth_freq_to_divider_words_top.sv =====
// Top level: carrier frequency to synthesizer divider, fraction and band words.
// Each beat on the slave stream carries a carrier frequency in hertz. The block
// picks an output divider and band from the four-band or six-band range table
// (first matching open range wins), computes fc = divider * freq * 2^18 /
// crystal_freq_hz with truncation, and returns one result beat holding the
// band code, divider, integer word ((fc >> 19) - 1, modulo 256), fraction word
// (fc bits 18..0 with bit 19 set) and clock-generator word (8 | band). A
// frequency outside every range gives status 1 in tuser and all-zero data. A
// zero crystal frequency yields fc of all ones. The block takes one beat per
// clock while the master side does not stall. Each result passes through 31
// registers: the range lookup register, loaded at the edge that accepts its
// request, the divider multiply register, 28 radix-4 divider stages of
// two quotient bits each, and the output register. A stall on the master
// side holds the whole pipeline; nothing is dropped or repeated. Registers:
// 0x0 wide_band_variant (bit 0), 0x4 crystal_freq_hz (bits 26..0). Write the
// registers only while no request is in flight.
module synth_freq_to_divider_words_top
  import sfdw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Request stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] carrier_hz
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] band_code, [7:3] out_divider,
                                 // [15:8] integer_word, [35:16] fraction_word,
                                 // [39:36] clkgen_word
  output logic        m_tuser,   // [0] status
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers. Decoding uses address bit 2 alone.
  logic              wide_band_variant;
  logic [XTAL_W-1:0] crystal_freq_hz;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_band_variant <= 1'b0;
      crystal_freq_hz   <= XTAL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_VARIANT: wide_band_variant <= pwdata[0];
        REG_XTAL:    crystal_freq_hz   <= pwdata[XTAL_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VARIANT: prdata = {31'd0, wide_band_variant};
      REG_XTAL:    prdata = {{(32-XTAL_W){1'b0}}, crystal_freq_hz};
      default:     prdata = '0;
    endcase
  end

  // The whole pipeline moves when the output register is empty or drained.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage A: range lookup.
  band_sel_t           sel;
  logic                a_valid;
  logic                a_err;
  logic [BAND_W-1:0]   a_band;
  logic [DIVSEL_W-1:0] a_div;
  logic [FREQ_W-1:0]   a_freq;

  assign sel = find_band(s_tdata, wide_band_variant);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
    if (en) begin
      a_err  <= !sel.hit;
      a_band <= sel.band;
      a_div  <= sel.div;   // zero on a miss, so the product is zero
      a_freq <= s_tdata;
    end
  end

  // Stage B loads the divider with divider * freq * 2^18; then one stage per
  // two quotient bits.
  logic [PROD_W-1:0] prod;
  div_pipe_t         pipe [N_DIV+1];

  assign prod = PROD_W'(a_div) * PROD_W'(a_freq);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= N_DIV; k++) begin
        pipe[k].valid <= 1'b0;
      end
    end else if (en) begin
      pipe[0].valid <= a_valid;
      pipe[0].err   <= a_err;
      pipe[0].band  <= a_band;
      pipe[0].div   <= a_div;
      pipe[0].rem   <= '0;
      pipe[0].dvd   <= DVD_W'({prod, {FC_SHIFT{1'b0}}});
      pipe[0].quot  <= '0;
      for (int k = 0; k < N_DIV; k++) begin
        pipe[k+1] <= div_step(pipe[k], crystal_freq_hz);
      end
    end
  end

  // Output formatting and result register.
  div_pipe_t         last;
  logic [FC_W-1:0]   fc;
  logic [INT_W-1:0]  int_word;
  logic [39:0]       data_next;

  assign last     = pipe[N_DIV];
  assign fc       = (crystal_freq_hz == '0) ? '1 : last.quot;
  assign int_word = fc[FRAC_W+INT_W-1:FRAC_W] - INT_W'(1);

  always_comb begin
    if (last.err) begin
      data_next = '0;
    end else begin
      data_next = {1'b1, last.band, 1'b1, fc[FRAC_W-1:0], int_word, last.div, last.band};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= last.valid;
    end
    if (en) begin
      m_tdata <= data_next;
      m_tuser <= last.err;
    end
  end

  // An accepted request always lands in the lookup stage.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> a_valid)
    else $error("accepted request missing from lookup stage");

  // A failed lookup carries no words at all.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("error result with nonzero words");

  // A successful result carries a legal divider that agrees with its band.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      ((m_tdata[7:3] == 5'd24 && m_tdata[2:0] == 3'd5) ||
       (m_tdata[7:3] == 5'd16 && m_tdata[2:0] == 3'd4) ||
       (m_tdata[7:3] == 5'd12 && m_tdata[2:0] == 3'd3) ||
       (m_tdata[7:3] == 5'd8  && m_tdata[2:0] == 3'd2) ||
       (m_tdata[7:3] == 5'd6  && m_tdata[2:0] == 3'd1) ||
       (m_tdata[7:3] == 5'd4  && m_tdata[2:0] == 3'd0)))
    else $error("divider and band disagree");

  // The lookup and last divider stage valid flags do not change while the pipeline is held.
  assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(a_valid) && $stable(pipe[N_DIV].valid)))
    else $error("pipeline moved during a stall");

endmodule
